@@ rtl/rdeq_pkg.sv @@
`default_nettype none
package rdeq_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [2:0]         req_code_t;
	typedef logic [1:0]         status_t;

	localparam req_code_t REQ_PUSH_REAR  = 3'd0;
	localparam req_code_t REQ_PUSH_FRONT = 3'd1;
	localparam req_code_t REQ_POP_REAR   = 3'd2;
	localparam req_code_t REQ_POP_FRONT  = 3'd3;
	localparam req_code_t REQ_READ_ALL   = 3'd4;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_EMPTY  = 2'd2;
	localparam status_t ST_FORBID = 2'd3;

	localparam logic MODE_IN_RESTRICTED  = 1'b0;
	localparam logic MODE_OUT_RESTRICTED = 1'b1;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT,
		CELL_WRAP
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/rdeq_if.sv @@
`default_nettype none
interface rdeq_req_if;
	logic              valid;
	logic              ready;
	rdeq_pkg::req_code_t req_type;
	rdeq_pkg::word_t   push_value;

	modport source(output valid, output req_type, output push_value, input ready);
	modport sink(input valid, input req_type, input push_value, output ready);
endinterface

interface rdeq_res_if #(parameter int CNT_W = 4);
	logic              valid;
	logic              ready;
	rdeq_pkg::word_t   data_word;
	rdeq_pkg::status_t status;
	logic              last;
	logic [CNT_W-1:0]  occupancy;

	modport source(output valid, output data_word, output status, output last,
		output occupancy, input ready);
	modport sink(input valid, input data_word, input status, input last,
		input occupancy, output ready);
endinterface
`default_nettype wire

@@ rtl/rdeq_cell.sv @@
`default_nettype none
module rdeq_cell (
	input  wire                      clk,
	input  wire rdeq_pkg::cell_ctrl_t ctrl,
	input  wire rdeq_pkg::word_t     load_val,
	input  wire rdeq_pkg::word_t     prev_val,
	input  wire rdeq_pkg::word_t     next_val,
	input  wire rdeq_pkg::word_t     wrap_val,
	output rdeq_pkg::word_t          val
);
	import rdeq_pkg::*;

	word_t val_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_HOLD:      val_q <= val_q;
			CELL_LOAD:      val_q <= load_val;
			CELL_FROM_PREV: val_q <= prev_val;
			CELL_FROM_NEXT: val_q <= next_val;
			CELL_WRAP:      val_q <= wrap_val;
			default:        val_q <= val_q;
		endcase
	end

	assign val = val_q;
endmodule
`default_nettype wire

@@ rtl/restricted_double_ended_queue.sv @@
// the result of an accepted request is registered in the output register
// push and pop requests: one per cycle while the output side keeps up and no read all is in progress
// read all: one entry per cycle from the cell chain while the output side keeps up
// the next request waits until the rotation through the cells completes
// reset clears the count, the mode and the control; cell contents stay undefined
`default_nettype none
module restricted_double_ended_queue #(
	parameter int DEPTH = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	rdeq_req_if.sink    req,
	rdeq_res_if.source  res,
	input  wire         cfg_wr_en,
	input  wire         cfg_wr_data
);
	import rdeq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic          mode_q;
	logic [CW-1:0] count_q;
	logic          busy_q;
	logic [IW-1:0] rd_idx_q;
	logic          out_valid_q;
	word_t         out_data_q;
	status_t       out_status_q;
	logic          out_last_q;
	logic [CW-1:0] out_occ_q;

	word_t      cell_val [DEPTH];
	cell_ctrl_t cell_ctrl [DEPTH];

	logic          slot_free;
	logic          accept;
	logic          step;
	logic          step_last;
	logic          load_res;
	logic          start_read;
	logic [CW-1:0] rear_cnt;
	logic [IW-1:0] rear_idx;
	logic          is_full;
	logic          is_empty;
	logic          forbid;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PUSH_REAR,
		ACT_PUSH_FRONT,
		ACT_POP_FRONT,
		ACT_ROTATE
	} act_t;

	act_t          act;
	logic [CW-1:0] count_d;
	word_t         res_data;
	status_t       res_status;

	assign slot_free = !out_valid_q || res.ready;
	assign req.ready = !busy_q && slot_free;
	assign accept    = req.valid && req.ready;
	assign step      = busy_q && slot_free;
	assign rear_cnt  = count_q - CW'(1);
	assign rear_idx  = rear_cnt[IW-1:0];
	assign step_last = (rd_idx_q == rear_idx);
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);

	always_comb begin
		forbid = (req.req_type > REQ_READ_ALL) ||
			(req.req_type == REQ_PUSH_FRONT && mode_q == MODE_IN_RESTRICTED) ||
			(req.req_type == REQ_POP_REAR && mode_q == MODE_OUT_RESTRICTED);
	end

	always_comb begin
		act        = ACT_NONE;
		count_d    = count_q;
		res_data   = '0;
		res_status = ST_OK;
		start_read = 1'b0;
		if (step) begin
			act = ACT_ROTATE;
		end else if (accept && forbid) begin
			res_status = ST_FORBID;
		end else if (accept) begin
			unique case (req.req_type) inside
				REQ_PUSH_REAR, REQ_PUSH_FRONT: begin
					if (is_full) begin
						res_status = ST_FULL;
					end else begin
						act     = (req.req_type == REQ_PUSH_REAR) ? ACT_PUSH_REAR
							: ACT_PUSH_FRONT;
						count_d = count_q + CW'(1);
					end
				end
				REQ_POP_REAR: begin
					if (is_empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_data = cell_val[rear_idx];
						count_d  = rear_cnt;
					end
				end
				REQ_POP_FRONT: begin
					if (is_empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_data = cell_val[0];
						act      = ACT_POP_FRONT;
						count_d  = rear_cnt;
					end
				end
				default: begin
					if (is_empty) begin
						res_status = ST_EMPTY;
					end else begin
						start_read = 1'b1;
					end
				end
			endcase
		end
	end

	assign load_res = accept && !start_read;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t prev_v;
		word_t next_v;

		if (i == 0) begin : g_first
			assign prev_v = req.push_value;
		end else begin : g_prev
			assign prev_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_next
			assign next_v = cell_val[i+1];
		end

		always_comb begin
			cell_ctrl[i].op = CELL_HOLD;
			unique case (act)
				ACT_PUSH_REAR: begin
					if (count_q == CW'(i)) cell_ctrl[i].op = CELL_LOAD;
				end
				ACT_PUSH_FRONT: begin
					cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
				end
				ACT_POP_FRONT: begin
					cell_ctrl[i].op = CELL_FROM_NEXT;
				end
				ACT_ROTATE: begin
					if (rear_cnt == CW'(i)) cell_ctrl[i].op = CELL_WRAP;
					else if (rear_cnt > CW'(i)) cell_ctrl[i].op = CELL_FROM_NEXT;
				end
				default: cell_ctrl[i].op = CELL_HOLD;
			endcase
		end

		rdeq_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.load_val (req.push_value),
			.prev_val (prev_v),
			.next_val (next_v),
			.wrap_val (cell_val[0]),
			.val      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IN_RESTRICTED;
			count_q     <= '0;
			busy_q      <= 1'b0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			count_q <= count_d;
			if (start_read) begin
				busy_q   <= 1'b1;
				rd_idx_q <= '0;
			end else if (step) begin
				rd_idx_q <= rd_idx_q + IW'(1);
				if (step_last) busy_q <= 1'b0;
			end
			if (load_res || step) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q   <= cell_val[0];
			out_status_q <= ST_OK;
			out_last_q   <= step_last;
			out_occ_q    <= count_q;
		end else if (load_res) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
			out_last_q   <= 1'b1;
			out_occ_q    <= count_d;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.data_word = out_data_q;
	assign res.status    = out_status_q;
	assign res.last      = out_last_q;
	assign res.occupancy = out_occ_q;
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
module testbench;
	import rdeq_pkg::*;

	localparam int DEPTH = 8;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam req_code_t REQ_BAD_LO = 3'd5;
	localparam req_code_t REQ_BAD_HI = 3'd7;
	localparam int MAX_SHOWN = 10;
	localparam int PHASE_ITEMS = 38;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		req_code_t op;
		word_t     value;
	} deque_req_t;

	typedef struct {
		word_t            data;
		status_t          st;
		logic             last;
		logic [OCC_W-1:0] occ;
	} deque_result_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      drv_valid = 1'b0;
	req_code_t drv_op = REQ_PUSH_REAR;
	word_t     drv_value = '0;
	logic      rcv_ready = 1'b0;
	logic      cfg_wr_en = 1'b0;
	logic      cfg_wr_data = 1'b0;

	int   src_idle_pct = 0;
	int   sink_idle_pct = 0;
	logic sink_stall = 1'b0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	logic mode_shadow = MODE_IN_RESTRICTED;

	deque_req_t       pending_reqs[$];
	deque_result_t    expected_results[$];
	word_t            entry_shadow[DEPTH];
	logic [IDX_W-1:0] front_slot = '0;
	logic [OCC_W-1:0] fill_count = '0;
	int               fail_count = 0;
	int               queued_count = 0;

	rdeq_req_if req_bus();
	rdeq_res_if #(.CNT_W(OCC_W)) res_bus();

	assign req_bus.valid      = drv_valid;
	assign req_bus.req_type   = drv_op;
	assign req_bus.push_value = drv_value;
	assign res_bus.ready      = rcv_ready;

	restricted_double_ended_queue #(
		.DEPTH(DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_bus),
		.res        (res_bus),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic predict_deque(input req_code_t op, input word_t value);
		deque_result_t r;
		logic [IDX_W-1:0] slot;
		int i;
		r.data = '0;
		r.st = ST_OK;
		r.last = 1'b1;
		if (op > REQ_READ_ALL
				|| (op == REQ_PUSH_FRONT && mode_shadow == MODE_IN_RESTRICTED)
				|| (op == REQ_POP_REAR && mode_shadow == MODE_OUT_RESTRICTED)) begin
			r.st = ST_FORBID;
		end else if ((op == REQ_PUSH_REAR || op == REQ_PUSH_FRONT) && fill_count == DEPTH) begin
			r.st = ST_FULL;
		end else if (op != REQ_PUSH_REAR && op != REQ_PUSH_FRONT && fill_count == 0) begin
			r.st = ST_EMPTY;
		end else begin
			case (op)
				REQ_PUSH_REAR: begin
					slot = front_slot + fill_count[IDX_W-1:0];
					entry_shadow[slot] = value;
					fill_count++;
				end
				REQ_PUSH_FRONT: begin
					front_slot--;
					entry_shadow[front_slot] = value;
					fill_count++;
				end
				REQ_POP_REAR: begin
					slot = front_slot + fill_count[IDX_W-1:0] - 1'b1;
					r.data = entry_shadow[slot];
					fill_count--;
				end
				REQ_POP_FRONT: begin
					r.data = entry_shadow[front_slot];
					front_slot++;
					fill_count--;
				end
				default: begin
					for (i = 0; i < fill_count; i++) begin
						slot = front_slot + i[IDX_W-1:0];
						r.data = entry_shadow[slot];
						r.last = (i == fill_count - 1);
						r.occ = fill_count;
						expected_results.push_back(r);
					end
					return;
				end
			endcase
		end
		r.occ = fill_count;
		expected_results.push_back(r);
	endtask

	// driver
	always @(posedge clk) begin
		deque_req_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || req_bus.ready) begin
			if (drv_valid) begin
				predict_deque(drv_op, drv_value);
			end
			if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = pending_reqs.pop_front();
				drv_op <= nxt.op;
				drv_value <= nxt.value;
				drv_valid <= 1'b1;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		deque_result_t want;
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (res_bus.valid && rcv_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN) begin
						$display("unexpected transaction: data %0d status %0d last %0b occupancy %0d",
							res_bus.data_word, res_bus.status, res_bus.last, res_bus.occupancy);
					end
				end else begin
					want = expected_results.pop_front();
					if (res_bus.data_word !== want.data || res_bus.status !== want.st
							|| res_bus.last !== want.last || res_bus.occupancy !== want.occ) begin
						fail_count++;
						if (fail_count <= MAX_SHOWN) begin
							$display("mismatch: expected data %0d status %0d last %0b occupancy %0d",
								want.data, want.st, want.last, want.occ);
							$display("          actual   data %0d status %0d last %0b occupancy %0d",
								res_bus.data_word, res_bus.status, res_bus.last, res_bus.occupancy);
						end
					end
				end
			end
			rcv_ready <= !sink_stall && $urandom_range(99) >= sink_idle_pct;
		end
	end

	// receiver hold-off
	initial begin
		wait (hold_go);
		sink_stall <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_stall <= 1'b0;
		hold_done <= 1'b1;
	end

	task automatic queue_req(input req_code_t op, input word_t value);
		deque_req_t it;
		it.op = op;
		it.value = value;
		pending_reqs.push_back(it);
		queued_count++;
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic set_mode(input logic m);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		mode_shadow <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic settle();
		while (pending_reqs.size() != 0 || drv_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * DEPTH + 4) @(posedge clk);
	endtask

	task automatic random_burst(input logic m);
		int kind;
		int len;
		kind = $urandom_range(99);
		len = $urandom_range(1, DEPTH + 2);
		if (kind < 40) begin
			repeat (len) begin
				queue_req((m == MODE_OUT_RESTRICTED && $urandom_range(1)) ?
					REQ_PUSH_FRONT : REQ_PUSH_REAR, rand_word());
			end
		end else if (kind < 75) begin
			repeat (len) begin
				queue_req((m == MODE_IN_RESTRICTED && $urandom_range(1)) ?
					REQ_POP_REAR : REQ_POP_FRONT, rand_word());
			end
		end else if (kind < 88) begin
			queue_req(REQ_READ_ALL, rand_word());
		end else if ($urandom_range(3) == 0) begin
			queue_req(m == MODE_IN_RESTRICTED ? REQ_PUSH_FRONT : REQ_POP_REAR, rand_word());
		end else begin
			queue_req(req_code_t'($urandom_range(REQ_BAD_HI, REQ_BAD_LO)), rand_word());
		end
	endtask

	task automatic random_phase(input logic m, input int n);
		int target;
		target = queued_count + n;
		while (queued_count < target) begin
			random_burst(m);
		end
	endtask

	initial begin
		word_t corner_words[8];
		corner_words = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1,
			32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0};
		corner_words[7] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// input restricted: empty, refused, fill to full, read all, pop at both ends
		set_mode(MODE_IN_RESTRICTED);
		queue_req(REQ_POP_REAR, '0);
		queue_req(REQ_POP_FRONT, '0);
		queue_req(REQ_READ_ALL, '0);
		queue_req(REQ_PUSH_FRONT, 32'sh1234_5678);
		queue_req(REQ_BAD_LO, '0);
		queue_req(REQ_BAD_HI, '1);
		foreach (corner_words[k]) begin
			queue_req(REQ_PUSH_REAR, corner_words[k]);
		end
		queue_req(REQ_PUSH_REAR, 32'sh0bad_cafe);
		queue_req(REQ_PUSH_FRONT, '1);
		queue_req(REQ_READ_ALL, '0);
		queue_req(REQ_POP_REAR, '0);
		queue_req(REQ_POP_FRONT, '0);
		settle();

		// output restricted: front wraps below slot zero
		set_mode(MODE_OUT_RESTRICTED);
		queue_req(REQ_PUSH_FRONT, 32'sh8000_0001);
		queue_req(REQ_PUSH_FRONT, 32'sh7fff_fffe);
		queue_req(REQ_PUSH_FRONT, 32'sh1111_1111);
		queue_req(REQ_POP_REAR, '0);
		queue_req(REQ_POP_FRONT, '0);
		queue_req(REQ_READ_ALL, '0);
		settle();

		src_idle_pct <= 35;
		sink_idle_pct <= 68;
		set_mode(MODE_IN_RESTRICTED);
		random_phase(MODE_IN_RESTRICTED, PHASE_ITEMS);
		settle();

		src_idle_pct <= 68;
		sink_idle_pct <= 35;
		set_mode(MODE_OUT_RESTRICTED);
		random_phase(MODE_OUT_RESTRICTED, PHASE_ITEMS);
		settle();

		// long receiver hold-off while the sender keeps offering
		src_idle_pct <= 0;
		sink_idle_pct <= 0;
		set_mode(MODE_IN_RESTRICTED);
		hold_go <= 1'b1;
		repeat (DEPTH + 4) queue_req(REQ_PUSH_REAR, rand_word());
		queue_req(REQ_READ_ALL, '0);
		repeat (4) queue_req(REQ_POP_FRONT, '0);
		wait (hold_done);
		random_phase(MODE_IN_RESTRICTED, PHASE_ITEMS);
		settle();

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
